[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SPSR_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication
`define SPSR_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

[sv/spsr_pkg.sv]
// ----------------------------------------------------------------------------
// spsr_pkg
// codes, types and the phase tables of the stepper phase sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spsr_pkg;

  localparam int PHASE_COUNT = 8;
  localparam int PHASE_W = $clog2(PHASE_COUNT);

  // command codes
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_SPEED = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_ON    = 3'd3;
  localparam logic [2:0] OP_OFF   = 3'd4;
  localparam logic [2:0] OP_STEP  = 3'd5;

  // motion states
  localparam logic [2:0] MS_STOPPED    = 3'd0;
  localparam logic [2:0] MS_ACCEL      = 3'd1;
  localparam logic [2:0] MS_CRUISE     = 3'd2;
  localparam logic [2:0] MS_DECEL      = 3'd3;
  localparam logic [2:0] MS_DECEL_STOP = 3'd4;

  // run directions
  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_CW   = 2'b01;
  localparam logic [1:0] DIR_CCW  = 2'b11;

  // register indexes
  localparam logic [1:0] REG_STEP_MODE = 2'd0;
  localparam logic [1:0] REG_SLOWEST   = 2'd1;
  localparam logic [1:0] REG_FASTEST   = 2'd2;
  localparam logic [1:0] REG_RAMP_STEP = 2'd3;

  localparam logic [7:0] SLOWEST_RESET = 8'd32;
  localparam logic [7:0] FASTEST_RESET = 8'd0;
  localparam logic [3:0] RAMP_RESET    = 4'd1;

  typedef struct packed {
    logic [1:0] step_mode;
    logic [7:0] slowest;
    logic [7:0] fastest;
    logic [3:0] ramp_step;
  } cfg_t;

  typedef struct packed {
    logic               powered;
    logic               holding;
    logic               stepped_once;
    logic [PHASE_W-1:0] phase;
    logic [2:0]         motion;
    logic [1:0]         run_dir;
    logic [7:0]         last_speed;
    logic [7:0]         delay;
    logic [8:0]         offset;
    logic [15:0]        ticks;
  } st_t;

  // results of one command, all fields but coils and update are shared
  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][3:0] coils;
    logic [2:0]      update;
    logic [2:0]      motion;
    logic [7:0]      delay;
    logic            changed;
  } res_t;

  // coil pattern a+ a- b+ b-, unused mode falls back to single phase
  function automatic logic [3:0] phase_pattern(input logic [1:0] mode,
                                               input logic [PHASE_W-1:0] idx);
    logic [3:0] p;
    case (mode)
      2'd1: begin
        case (idx[1:0])
          2'd0:    p = 4'd9;
          2'd1:    p = 4'd10;
          2'd2:    p = 4'd6;
          default: p = 4'd5;
        endcase
      end
      2'd2: begin
        case (idx)
          3'd0:    p = 4'd9;
          3'd1:    p = 4'd8;
          3'd2:    p = 4'd14;
          3'd3:    p = 4'd6;
          3'd4:    p = 4'd6;
          3'd5:    p = 4'd7;
          3'd6:    p = 4'd1;
          default: p = 4'd9;
        endcase
      end
      default: begin
        case (idx[1:0])
          2'd0:    p = 4'd8;
          2'd1:    p = 4'd2;
          2'd2:    p = 4'd4;
          default: p = 4'd1;
        endcase
      end
    endcase
    return p;
  endfunction

endpackage

[sv/spsr_step.sv]
// ----------------------------------------------------------------------------
// spsr_step
// next motion state and result set for one command or tick
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spsr_step (
  input  spsr_pkg::cfg_t    cfg,
  input  spsr_pkg::st_t     st,
  input  logic [2:0]        op,
  input  logic signed [7:0] speed_request,
  input  logic              hold_on_stop,
  input  logic signed [1:0] step_direction,
  output spsr_pkg::st_t     st_next,
  output spsr_pkg::res_t    res
);
  import spsr_pkg::*;

  function automatic logic [7:0] clamp_target(input logic signed [10:0] x,
                                              input logic [7:0] hi_v,
                                              input logic [7:0] lo_v);
    logic signed [10:0] v;
    v = x;
    if (v > $signed({3'b000, hi_v})) v = $signed({3'b000, hi_v});
    if (v < $signed({3'b000, lo_v})) v = $signed({3'b000, lo_v});
    return v[7:0];
  endfunction

  always_comb begin
    st_t                s;
    logic               ch;
    logic [1:0]         n;
    logic [2:0][3:0]    c;
    logic [2:0]         u;
    logic               stop_req;
    logic               stop_hold;
    logic               do_fast;
    logic               do_slow;
    logic signed [7:0]  sp;
    logic signed [9:0]  ofs;
    logic signed [9:0]  stp;
    logic signed [10:0] t;
    logic signed [10:0] diff;
    logic [1:0]         sdir;

    s = st;
    ch = 1'b0;
    n = 2'd0;
    c = '0;
    u = '0;
    stop_req = 1'b0;
    stop_hold = 1'b0;
    do_fast = 1'b0;
    do_slow = 1'b0;
    sp = speed_request;
    ofs = '0;
    stp = '0;
    t = '0;
    diff = '0;
    sdir = DIR_NONE;

    case (op)
      OP_TICK: begin
        if (s.ticks != 16'hFFFF) s.ticks = s.ticks + 16'd1;
        if (s.powered && (s.motion != MS_STOPPED || s.holding)) begin
          if (s.run_dir != DIR_NONE) begin
            if (!s.stepped_once || s.ticks > {8'd0, s.delay}) begin
              c[0] = phase_pattern(cfg.step_mode, s.phase);
              u[0] = 1'b1;
              n = 2'd1;
              s.phase = s.phase + {s.run_dir[1], s.run_dir};
              if (s.motion == MS_ACCEL || s.motion == MS_DECEL ||
                  s.motion == MS_DECEL_STOP) begin
                // one ramp step toward the target, never past it
                ofs = {s.offset[8], s.offset};
                stp = $signed({6'd0, cfg.ramp_step});
                if (ofs < 0) begin
                  if (stp > -ofs) stp = -ofs;
                  s.delay = s.delay - stp[7:0];
                  s.offset = s.offset + stp[8:0];
                end else if (ofs > 0) begin
                  if (stp > ofs) stp = ofs;
                  s.delay = s.delay + stp[7:0];
                  s.offset = s.offset - stp[8:0];
                end
                if (s.offset == 9'd0) begin
                  if (s.motion == MS_DECEL_STOP) begin
                    s.motion = MS_STOPPED;
                    s.run_dir = DIR_NONE;
                    if (!s.holding) begin
                      u[1] = 1'b1;
                      n = 2'd2;
                    end
                  end else begin
                    s.motion = MS_CRUISE;
                  end
                end
              end
              s.ticks = 16'd0;
              s.stepped_once = 1'b1;
              ch = 1'b1;
            end
          end else if (s.holding) begin
            c[0] = phase_pattern(cfg.step_mode, s.phase);
            u[0] = 1'b1;
            n = 2'd1;
          end
        end
      end
      OP_SPEED: begin
        if (sp == 8'sd0 && s.last_speed != 8'd0) begin
          stop_req = 1'b1;
          stop_hold = 1'b1;
          s.last_speed = 8'd0;
        end else if (sp > $signed(s.last_speed)) begin
          if (s.motion == MS_STOPPED || s.run_dir == DIR_CCW) begin
            s.delay = cfg.slowest;
            s.run_dir = DIR_CW;
            s.motion = MS_STOPPED;
            s.phase = '0;
            s.holding = 1'b1;
          end
          do_fast = 1'b1;
          s.last_speed = sp;
        end else if (sp < $signed(s.last_speed)) begin
          if (s.motion == MS_STOPPED || s.run_dir == DIR_CW) begin
            s.delay = cfg.slowest;
            s.run_dir = DIR_CCW;
            s.motion = MS_STOPPED;
            s.phase = '0;
            s.holding = 1'b1;
          end
          do_slow = 1'b1;
          s.last_speed = sp;
        end
      end
      OP_STOP: begin
        stop_req = 1'b1;
        stop_hold = hold_on_stop;
      end
      OP_ON, OP_OFF: begin
        if (s.powered == (op == OP_OFF)) begin
          u[0] = 1'b1;
          n = 2'd1;
          s.run_dir = DIR_NONE;
          s.motion = MS_STOPPED;
          s.last_speed = 8'd0;
          s.delay = cfg.slowest;
          s.phase = '0;
          s.offset = 9'd0;
          s.holding = 1'b0;
          s.powered = (op == OP_ON);
          ch = 1'b1;
        end
      end
      OP_STEP: begin
        if (s.motion == MS_STOPPED && !s.holding) begin
          // current pattern, advanced pattern, then coils off
          c[0] = phase_pattern(cfg.step_mode, s.phase);
          if (step_direction == 2'sd1) sdir = DIR_CW;
          else if (step_direction == 2'sd0) sdir = DIR_NONE;
          else sdir = DIR_CCW;
          s.phase = s.phase + {sdir[1], sdir};
          c[1] = phase_pattern(cfg.step_mode, s.phase);
          u = 3'b111;
          n = 2'd3;
          s.run_dir = DIR_NONE;
          ch = 1'b1;
        end
      end
      default: ;
    endcase

    t = $signed({3'b000, s.delay}) + $signed({{2{s.offset[8]}}, s.offset});

    if (do_fast) begin
      if (t > $signed({3'b000, cfg.fastest})) begin
        diff = $signed({3'b000, clamp_target(t - $signed({7'd0, cfg.ramp_step}),
                                              cfg.slowest, cfg.fastest)})
               - $signed({3'b000, s.delay});
        s.offset = diff[8:0];
        if (s.offset[8]) s.motion = MS_ACCEL;
        else if (s.offset == 9'd0) s.motion = MS_CRUISE;
        ch = 1'b1;
      end
    end

    if (do_slow) begin
      if (!(s.motion == MS_STOPPED || t >= $signed({3'b000, cfg.slowest}))) begin
        diff = $signed({3'b000, clamp_target(t + $signed({7'd0, cfg.ramp_step}),
                                              cfg.slowest, cfg.fastest)})
               - $signed({3'b000, s.delay});
        s.offset = diff[8:0];
        s.motion = (s.offset == 9'd0) ? MS_CRUISE : MS_DECEL;
        ch = 1'b1;
      end
    end

    if (stop_req) begin
      if (s.motion != MS_DECEL_STOP && s.motion != MS_STOPPED) begin
        s.holding = stop_hold;
        s.motion = MS_DECEL_STOP;
        diff = $signed({3'b000, cfg.slowest}) - $signed({3'b000, s.delay});
        s.offset = diff[8:0];
        ch = 1'b1;
      end else if (s.motion == MS_STOPPED && !stop_hold && s.holding) begin
        // release holding torque
        u[0] = 1'b1;
        n = 2'd1;
        s.holding = 1'b0;
        ch = 1'b1;
      end
    end

    // nothing driven: one result with the coils left alone
    if (n == 2'd0) n = 2'd1;

    st_next = s;
    res.count = n;
    res.coils = c;
    res.update = u;
    res.motion = s.motion;
    res.delay = s.delay;
    res.changed = ch;
  end

endmodule

[sv/stepper_phase_sequencer_ramp_core.sv]
// ----------------------------------------------------------------------------
// stepper_phase_sequencer_ramp_core
// bipolar stepper coil sequencer with linear step-delay ramp
// ----------------------------------------------------------------------------
// A command or tick is evaluated in the cycle it is accepted and its results
// (one, two for a tick that ends a ramp-down without holding, three for a
// manual step) land in a result register that hands out one result per cycle
// while res_stall is low. A transaction holds the result register until its
// last result is taken; the next command is taken in the cycle the last
// result of the previous one is taken, so single-result traffic runs at one
// per clock while res_stall is low. Registers are to be written through the
// plain write port while the block is idle; the block itself does not enforce it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stepper_phase_sequencer_ramp_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  logic [2:0]        op,
  input  logic signed [7:0] speed_request,
  input  logic              hold_on_stop,
  input  logic signed [1:0] step_direction,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [3:0]        coils,
  output logic              coils_update,
  output logic [2:0]        motion_state,
  output logic [7:0]        step_delay,
  output logic              changed,
  output logic              last
);
  import spsr_pkg::*;

  cfg_t       cfg;
  st_t        st;
  st_t        st_next;
  res_t       res_new;
  res_t       rbuf;
  logic       busy;
  logic [1:0] ptr;
  logic       res_last;
  logic       res_take;
  logic       done;
  logic       cmd_take;

  spsr_step u_step (
    .cfg            (cfg),
    .st             (st),
    .op             (op),
    .speed_request  (speed_request),
    .hold_on_stop   (hold_on_stop),
    .step_direction (step_direction),
    .st_next        (st_next),
    .res            (res_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_mode <= 2'd0;
      cfg.slowest <= SLOWEST_RESET;
      cfg.fastest <= FASTEST_RESET;
      cfg.ramp_step <= RAMP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STEP_MODE: cfg.step_mode <= cfg_data[1:0];
        REG_SLOWEST:   cfg.slowest <= cfg_data;
        REG_FASTEST:   cfg.fastest <= cfg_data;
        REG_RAMP_STEP: cfg.ramp_step <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign res_last = (ptr == rbuf.count - 2'd1);
  assign res_take = busy && !res_stall;
  assign done = res_take && res_last;
  assign cmd_stall = busy && !done;
  assign cmd_take = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ptr <= 2'd0;
      st.powered <= 1'b0;
      st.holding <= 1'b0;
      st.stepped_once <= 1'b0;
      st.phase <= '0;
      st.motion <= MS_STOPPED;
      st.run_dir <= DIR_NONE;
      st.last_speed <= 8'd0;
      st.delay <= SLOWEST_RESET;
      st.offset <= 9'd0;
      st.ticks <= 16'd0;
    end else if (cmd_take) begin
      st <= st_next;
      busy <= 1'b1;
      ptr <= 2'd0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (res_take) begin
      ptr <= ptr + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) rbuf <= res_new;
  end

  assign res_valid = busy;
  assign coils = rbuf.coils[ptr];
  assign coils_update = rbuf.update[ptr];
  assign motion_state = rbuf.motion;
  assign step_delay = rbuf.delay;
  assign changed = rbuf.changed;
  assign last = res_last;

  // a new command only replaces a result set whose last result leaves now
  `SPSR_ASSERT_IMP(a_take_on_final, cmd_valid && !cmd_stall && busy, !res_stall && res_last)
  // an accepted command shows its first result next cycle
  `SPSR_ASSERT_NXT(a_first_result, cmd_valid && !cmd_stall, res_valid && ptr == 2'd0)
  // a result that drives nothing is the only result of its transaction
  `SPSR_ASSERT_IMP(a_quiet_single, res_valid && !coils_update, res_last && coils == 4'd0)

endmodule
